// ----- hdl/sfba_pkg.sv -----
// ----------------------------------------------------------------------------
// sfba_pkg
// Shared types, constants and register codes for the flow breath analyzer.
// ----------------------------------------------------------------------------
package sfba_pkg;

  // Configuration register indexes.
  localparam logic [2:0] CFG_ADC_GAIN      = 3'd0;
  localparam logic [2:0] CFG_ADC_INTERCEPT = 3'd1;
  localparam logic [2:0] CFG_FLOW_OFFSET   = 3'd2;
  localparam logic [2:0] CFG_DEADBAND      = 3'd3;
  localparam logic [2:0] CFG_EXHALE_THR    = 3'd4;
  localparam logic [2:0] CFG_SAMPLE_PERIOD = 3'd5;
  localparam logic [2:0] CFG_END_HOLD      = 3'd6;

  // Breath phase codes.
  localparam logic [1:0] PH_IDLE     = 2'd0;
  localparam logic [1:0] PH_EXHALE   = 2'd1;
  localparam logic [1:0] PH_COMPLETE = 2'd2;

  // Default depth of the queue between front and back.
  localparam int QUEUE_DEPTH_DEF = 4;

  // Ratio divider sizes.
  localparam int DIV_NUM_W = 64;
  localparam int DIV_DEN_W = 40;
  localparam int DIV_CNT_W = 7;

  // Numerator bit count for the ratio division.
  localparam logic [DIV_CNT_W-1:0] RATIO_DIV_BITS = 7'd55;

  // Reciprocals for the constant divisions. ceil(2^34/30) is exact for
  // numerators below 2^28; ceil(2^49/15625) is exact for numerators below 2^36.
  localparam logic [29:0] FLOW_RECIP = 30'd572662307;
  localparam logic [35:0] VOL_RECIP  = 36'd36028797019;

  // Arithmetic limits.
  localparam logic [23:0] SLPM_MAX = 24'd9830400;
  localparam logic [21:0] FLOW_MAX = 22'd2621440;
  localparam logic signed [39:0] VOL_MAX = 40'sd549755813887;
  localparam logic [31:0] FEV1_TIME = 32'd1000000;
  localparam logic [31:0] FEV6_TIME = 32'd6000000;
  localparam logic signed [39:0] RATIO_MIN_FVC = 40'sd1049;
  localparam logic [16:0] RATIO_MAX = 17'd65536;

  // One queued sample word.
  typedef struct packed {
    logic [11:0] sample;
    logic [31:0] ts;
  } qitem_t;

  // Configuration register set.
  typedef struct packed {
    logic [15:0] adc_gain;
    logic [23:0] adc_intercept;
    logic [23:0] flow_offset;
    logic [23:0] deadband;
    logic [21:0] exhale_threshold;
    logic [19:0] sample_period_us;
    logic [23:0] end_hold_us;
  } cfg_t;

  // Queue read side seen by the back end.
  typedef struct packed {
    logic   valid;
    qitem_t item;
  } qrd_t;

endpackage

// ----- hdl/spirometry_flow_breath_analyzer.sv -----
// ----------------------------------------------------------------------------
// spirometry_flow_breath_analyzer
// Flow conditioning, volume integration and breath summary for a flow sensor.
// ----------------------------------------------------------------------------
// Usage:
//   Samples enter on in_valid/in_stall; a word is taken when in_valid is high
//   and in_stall is low. Faulted samples are taken and dropped without a
//   result. Every other sample yields one result word on out_valid/out_stall.
//   Registers are written through cfg_valid/cfg_ready (always ready);
//   index 0..6, other indexes are ignored. The user writes them only while
//   the block is idle; the block itself does not enforce this. Each queued
//   sample passes the back end's fixed sequence: conditioning, flow and
//   volume scaling by reciprocal multiplies, accumulation, breath update and
//   output. The sample that closes a breath may also run the bit-serial
//   FEV1/FVC divider over 55 numerator bits. The back end works on one
//   sample at a time; a four-word queue lets new samples be taken meanwhile.
//   While the receiver stalls, the finished word holds and the back end
//   waits with its next result; the queue then fills and raises in_stall.
//   Reset clears the queue, breath state and registers to defaults.
// ----------------------------------------------------------------------------
module spirometry_flow_breath_analyzer import sfba_pkg::*; #(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [11:0]        adc_sample,
  input  logic               adc_fault,
  input  logic [31:0]        timestamp_us,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [22:0] flow_now,
  output logic signed [39:0] volume_now,
  output logic [1:0]         phase,
  output logic               breath_done,
  output logic [31:0]        breath_number,
  output logic [38:0]        fvc,
  output logic signed [39:0] fev_one,
  output logic signed [39:0] fev_six,
  output logic [21:0]        peak_flow,
  output logic [16:0]        fev_ratio,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [23:0]        cfg_data
);

  cfg_t cfg;
  qrd_t q_rd;
  logic q_pop;

  assign cfg_ready = 1'b1;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.adc_gain         <= 16'd2704;
      cfg.adc_intercept    <= 24'd1241252;
      cfg.flow_offset      <= 24'd0;
      cfg.deadband         <= 24'd32768;
      cfg.exhale_threshold <= 22'd104858;
      cfg.sample_period_us <= 20'd10000;
      cfg.end_hold_us      <= 24'd300000;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_ADC_GAIN:      cfg.adc_gain         <= cfg_data[15:0];
        CFG_ADC_INTERCEPT: cfg.adc_intercept    <= cfg_data;
        CFG_FLOW_OFFSET:   cfg.flow_offset      <= cfg_data;
        CFG_DEADBAND:      cfg.deadband         <= cfg_data;
        CFG_EXHALE_THR:    cfg.exhale_threshold <= cfg_data[21:0];
        CFG_SAMPLE_PERIOD: cfg.sample_period_us <= cfg_data[19:0];
        CFG_END_HOLD:      cfg.end_hold_us      <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  sfba_front #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .adc_sample   (adc_sample),
    .adc_fault    (adc_fault),
    .timestamp_us (timestamp_us),
    .q_rd         (q_rd),
    .q_pop        (q_pop)
  );

  sfba_back u_back (
    .clk           (clk),
    .rst           (rst),
    .cfg           (cfg),
    .q_rd          (q_rd),
    .q_pop         (q_pop),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .flow_now      (flow_now),
    .volume_now    (volume_now),
    .phase         (phase),
    .breath_done   (breath_done),
    .breath_number (breath_number),
    .fvc           (fvc),
    .fev_one       (fev_one),
    .fev_six       (fev_six),
    .peak_flow     (peak_flow),
    .fev_ratio     (fev_ratio)
  );

endmodule

// ----- hdl/sfba_front.sv -----
// ----------------------------------------------------------------------------
// sfba_front
// Accepts samples, drops faulted ones and queues the rest for the back end.
// ----------------------------------------------------------------------------
module sfba_front import sfba_pkg::*; #(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [11:0] adc_sample,
  input  logic        adc_fault,
  input  logic [31:0] timestamp_us,
  output qrd_t        q_rd,
  input  logic        q_pop
);

  localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  qitem_t          mem [QUEUE_DEPTH];
  logic [PW-1:0]   wr_ptr;
  logic [PW-1:0]   rd_ptr;
  logic [CW-1:0]   count;
  logic            push;
  logic            pop;

  // The queue is full when every entry holds a word.
  assign in_stall = (count == CW'(QUEUE_DEPTH));
  assign push     = in_valid && !in_stall && !adc_fault;
  assign pop      = q_pop && (count != '0);

  assign q_rd.valid = (count != '0);
  assign q_rd.item  = mem[rd_ptr];

  // Storage writes.
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= '{sample: adc_sample, ts: timestamp_us};
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ----- hdl/sfba_div.sv -----
// ----------------------------------------------------------------------------
// sfba_div
// Bit-serial restoring divider for the FEV1/FVC ratio, one quotient bit per
// cycle.
// ----------------------------------------------------------------------------
module sfba_div import sfba_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic [DIV_NUM_W-1:0] num,
  input  logic [DIV_DEN_W-1:0] den,
  input  logic [DIV_CNT_W-1:0] bits,
  output logic                 done,
  output logic [DIV_NUM_W-1:0] quo
);

  logic [DIV_NUM_W-1:0] n;
  logic [DIV_DEN_W-1:0] den_r;
  logic [DIV_DEN_W-1:0] rem;
  logic [DIV_CNT_W-1:0] cnt;
  logic                 busy;
  logic [DIV_DEN_W:0]   trial;
  logic                 qbit;

  // One restoring step.
  assign trial = {rem, n[DIV_NUM_W-1]};
  assign qbit  = (trial >= {1'b0, den_r});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= !start && busy && (cnt == DIV_CNT_W'(1));
      if (start) begin
        busy <= 1'b1;
        cnt  <= bits;
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == DIV_CNT_W'(1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

  // Datapath: the numerator is left-aligned so only its live bits are walked.
  always_ff @(posedge clk) begin
    if (start) begin
      n     <= num << (DIV_CNT_W'(DIV_NUM_W) - bits);
      den_r <= den;
      rem   <= '0;
      quo   <= '0;
    end else if (busy) begin
      n   <= n << 1;
      rem <= qbit ? DIV_DEN_W'(trial - {1'b0, den_r}) : trial[DIV_DEN_W-1:0];
      quo <= {quo[DIV_NUM_W-2:0], qbit};
    end
  end

endmodule

// ----- hdl/sfba_back.sv -----
// ----------------------------------------------------------------------------
// sfba_back
// Conditions flow, integrates volume, runs the breath machine and holds the
// result word.
// ----------------------------------------------------------------------------
module sfba_back import sfba_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  cfg_t               cfg,
  input  qrd_t               q_rd,
  output logic               q_pop,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [22:0] flow_now,
  output logic signed [39:0] volume_now,
  output logic [1:0]         phase,
  output logic               breath_done,
  output logic [31:0]        breath_number,
  output logic [38:0]        fvc,
  output logic signed [39:0] fev_one,
  output logic signed [39:0] fev_six,
  output logic [21:0]        peak_flow,
  output logic [16:0]        fev_ratio
);

  typedef enum logic [10:0] {
    ST_IDLE  = 11'b00000000001,
    ST_COND  = 11'b00000000010,
    ST_FDIV  = 11'b00000000100,
    ST_VMUL  = 11'b00000001000,
    ST_VRND  = 11'b00000010000,
    ST_VLO   = 11'b00000100000,
    ST_VHI   = 11'b00001000000,
    ST_VACC  = 11'b00010000000,
    ST_UPD   = 11'b00100000000,
    ST_RDIV  = 11'b01000000000,
    ST_OUT   = 11'b10000000000
  } st_t;

  st_t st;

  // Per-sample working registers.
  logic [31:0]        ts;
  logic [27:0]        prod;
  logic               fneg;
  logic [27:0]        fnum;
  logic signed [22:0] flow_r;
  logic [42:0]        prodv;
  logic               vneg;
  logic [35:0]        vx;
  logic [53:0]        vlo;
  logic [22:0]        vquo;
  logic               done_r;
  logic [16:0]        ratio_r;

  // Breath state.
  logic signed [22:0] prev_flow;
  logic signed [39:0] acc_volume;
  logic [1:0]         breath_phase;
  logic [31:0]        breath_count;
  logic [31:0]        phase_start_time;
  logic signed [39:0] start_volume;
  logic signed [39:0] max_exhaled;
  logic signed [39:0] one_second_volume;
  logic signed [39:0] six_second_volume;
  logic [21:0]        max_flow;
  logic               one_second_taken;
  logic               six_second_taken;
  logic               low_flow_active;
  logic [31:0]        low_flow_start;

  // Divider hookup.
  logic                 div_start;
  logic [DIV_NUM_W-1:0] div_num;
  logic [DIV_DEN_W-1:0] div_den;
  logic [DIV_CNT_W-1:0] div_bits;
  logic                 div_done;
  logic [DIV_NUM_W-1:0] div_quo;

  // Conditioning arithmetic.
  logic signed [28:0] s_raw;
  logic [23:0]        s_cl;
  logic signed [25:0] f_off;
  logic [24:0]        f_mag;
  logic               f_zero;
  logic [24:0]        f_eff;
  logic [57:0]        fprod;
  logic [23:0]        fq;
  logic [21:0]        fq_mag;

  // Volume and breath arithmetic.
  logic signed [23:0] vsum;
  logic [22:0]        vmag;
  logic [43:0]        vround;
  logic [53:0]        vlo_mul;
  logic [53:0]        vhi_mul;
  logic [71:0]        vhi_sum;
  logic signed [24:0] dvol;
  logic signed [40:0] acc_sum;
  logic signed [40:0] ex_raw;
  logic signed [39:0] exhaled;
  logic [31:0]        elapsed;
  logic signed [22:0] thr_s;
  logic               ratio_go;
  logic               out_free;

  sfba_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .bits  (div_bits),
    .done  (div_done),
    .quo   (div_quo)
  );

  // Gain, intercept, clamp, offset and deadband.
  always_comb begin
    s_raw = $signed({1'b0, prod}) - $signed({5'b0, cfg.adc_intercept});
    if (s_raw < 0) begin
      s_cl = '0;
    end else if (s_raw > $signed({5'b0, SLPM_MAX})) begin
      s_cl = SLPM_MAX;
    end else begin
      s_cl = s_raw[23:0];
    end
    f_off  = $signed({2'b0, s_cl}) - $signed({2'b0, cfg.flow_offset});
    f_mag  = (f_off < 0) ? 25'(-f_off) : 25'(f_off);
    f_zero = (f_mag < {1'b0, cfg.deadband});
    f_eff  = f_zero ? '0 : f_mag;
  end

  // Flow scaling: floor((8|f| + 15) / 30) by reciprocal multiply, saturated.
  always_comb begin
    fprod  = 58'(fnum) * 58'(FLOW_RECIP);
    fq     = fprod[57:34];
    fq_mag = (fq > 24'(FLOW_MAX)) ? FLOW_MAX : fq[21:0];
  end

  // Volume step and exhaled volume. The step divides by 2000000 as a shift
  // by 7 and a reciprocal multiply for 15625, split in two 36x18 products.
  always_comb begin
    vsum    = 24'(flow_r) + 24'(prev_flow);
    vmag    = (vsum < 0) ? 23'(-vsum) : 23'(vsum);
    vround  = 44'(prodv) + 44'd1000000;
    vlo_mul = 54'(vx) * 54'(VOL_RECIP[17:0]);
    vhi_mul = 54'(vx) * 54'(VOL_RECIP[35:18]);
    vhi_sum = {vhi_mul, 18'b0} + 72'(vlo);
    dvol    = vneg ? -$signed({2'b0, vquo}) : $signed({2'b0, vquo});
    acc_sum = 41'(acc_volume) + 41'(dvol);
    ex_raw  = 41'(acc_volume) - 41'(start_volume);
    if (ex_raw > 41'(VOL_MAX)) begin
      exhaled = VOL_MAX;
    end else if (ex_raw < -41'(VOL_MAX)) begin
      exhaled = -VOL_MAX;
    end else begin
      exhaled = ex_raw[39:0];
    end
    elapsed  = ts - phase_start_time;
    thr_s    = $signed({1'b0, cfg.exhale_threshold});
    ratio_go = (max_exhaled >= RATIO_MIN_FVC) && (one_second_volume > 0);
    out_free = !out_valid || !out_stall;
  end

  // Ratio divider operands.
  assign div_start = (st == ST_UPD) && (breath_phase == PH_COMPLETE) && ratio_go;
  assign div_num   = DIV_NUM_W'({one_second_volume[38:0], 16'b0});
  assign div_den   = DIV_DEN_W'(max_exhaled);
  assign div_bits  = RATIO_DIV_BITS;

  assign q_pop = (st == ST_IDLE) && q_rd.valid;

  // Sequencer and breath machine.
  always_ff @(posedge clk) begin
    if (rst) begin
      st                <= ST_IDLE;
      out_valid         <= 1'b0;
      prev_flow         <= '0;
      acc_volume        <= '0;
      breath_phase      <= PH_IDLE;
      breath_count      <= '0;
      phase_start_time  <= '0;
      start_volume      <= '0;
      max_exhaled       <= '0;
      one_second_volume <= '0;
      six_second_volume <= '0;
      max_flow          <= '0;
      one_second_taken  <= 1'b0;
      six_second_taken  <= 1'b0;
      low_flow_active   <= 1'b0;
      low_flow_start    <= '0;
    end else begin
      if ((st == ST_OUT) && out_free) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      case (st)
        ST_IDLE: begin
          if (q_rd.valid) begin
            ts   <= q_rd.item.ts;
            prod <= q_rd.item.sample * cfg.adc_gain;
            st   <= ST_COND;
          end
        end
        ST_COND: begin
          fneg <= (f_off < 0) && !f_zero;
          fnum <= {f_eff, 3'b0} + 28'd15;
          st   <= ST_FDIV;
        end
        ST_FDIV: begin
          flow_r <= fneg ? -$signed({1'b0, fq_mag}) : $signed({1'b0, fq_mag});
          st     <= ST_VMUL;
        end
        ST_VMUL: begin
          vneg  <= (vsum < 0);
          prodv <= vmag * cfg.sample_period_us;
          st    <= ST_VRND;
        end
        ST_VRND: begin
          vx <= vround[42:7];
          st <= ST_VLO;
        end
        ST_VLO: begin
          vlo <= vlo_mul;
          st  <= ST_VHI;
        end
        ST_VHI: begin
          vquo <= vhi_sum[71:49];
          st   <= ST_VACC;
        end
        ST_VACC: begin
          if (acc_sum > 41'(VOL_MAX)) begin
            acc_volume <= VOL_MAX;
          end else if (acc_sum < -41'(VOL_MAX)) begin
            acc_volume <= -VOL_MAX;
          end else begin
            acc_volume <= acc_sum[39:0];
          end
          prev_flow <= flow_r;
          st        <= ST_UPD;
        end
        ST_UPD: begin
          done_r  <= (breath_phase == PH_COMPLETE);
          ratio_r <= '0;
          st      <= ((breath_phase == PH_COMPLETE) && ratio_go) ? ST_RDIV : ST_OUT;
          case (breath_phase)
            PH_EXHALE: begin
              if (exhaled > max_exhaled) begin
                max_exhaled <= exhaled;
              end
              if (flow_r > $signed({1'b0, max_flow})) begin
                max_flow <= flow_r[21:0];
              end
              if (!one_second_taken && elapsed >= FEV1_TIME) begin
                one_second_volume <= exhaled;
                one_second_taken  <= 1'b1;
              end
              if (!six_second_taken && elapsed >= FEV6_TIME) begin
                six_second_volume <= exhaled;
                six_second_taken  <= 1'b1;
              end
              if (flow_r < thr_s) begin
                if (!low_flow_active) begin
                  low_flow_active <= 1'b1;
                  low_flow_start  <= ts;
                end else if ((ts - low_flow_start) > {8'b0, cfg.end_hold_us}) begin
                  breath_phase <= PH_COMPLETE;
                end
              end else begin
                low_flow_active <= 1'b0;
              end
            end
            PH_COMPLETE: begin
              breath_phase <= PH_IDLE;
            end
            default: begin
              if (flow_r > thr_s) begin
                breath_phase      <= PH_EXHALE;
                breath_count      <= breath_count + 1'b1;
                phase_start_time  <= ts;
                start_volume      <= acc_volume;
                max_exhaled       <= '0;
                one_second_volume <= '0;
                six_second_volume <= '0;
                max_flow          <= '0;
                one_second_taken  <= 1'b0;
                six_second_taken  <= 1'b0;
                low_flow_active   <= 1'b0;
                low_flow_start    <= '0;
              end else begin
                breath_phase <= PH_IDLE;
              end
            end
          endcase
        end
        ST_RDIV: begin
          if (div_done) begin
            ratio_r <= (div_quo > DIV_NUM_W'(RATIO_MAX)) ? RATIO_MAX : div_quo[16:0];
            st      <= ST_OUT;
          end
        end
        ST_OUT: begin
          if (out_free) begin
            st <= ST_IDLE;
          end
        end
        default: begin
          st <= ST_IDLE;
        end
      endcase
    end
  end

  // Result word, loaded when the output register is free.
  always_ff @(posedge clk) begin
    if ((st == ST_OUT) && out_free) begin
      flow_now      <= flow_r;
      volume_now    <= acc_volume;
      phase         <= breath_phase;
      breath_done   <= done_r;
      breath_number <= breath_count;
      fvc           <= done_r ? max_exhaled[38:0] : '0;
      fev_one       <= done_r ? one_second_volume : '0;
      fev_six       <= done_r ? six_second_volume : '0;
      peak_flow     <= done_r ? max_flow : '0;
      fev_ratio     <= done_r ? ratio_r : '0;
    end
  end

endmodule
